FILE: hw/rtl/lpht_pkg.sv
// Package for the linear-probing hash table: field widths, request modes
// and result status codes. No dependencies.
package lpht_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd6;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

FILE: hw/rtl/linear_probe_hash_table.sv
// Linear-probing hash table of short keys, with its key memory.
// Depends on lpht_pkg.
//
// Usage: each s_axis input word carries one request (insert, delete or search) and one
// key, and yields exactly one m_axis output word with the status, the slot touched, the
// occupied count and the empty and full flags. The user writes the capacity register
// through i_cfg_wen / i_cfg_wdata only while it is idle; the block does not enforce this.
//
// Operation: one request at a time. A restoring divider forms the home slot from the
// byte sum, one bit per cycle; the probe then reads one slot per cycle, one read ahead.
// A zero key skips both steps and goes straight to the finish state, from which its
// result is loaded into the output register.
//
// Reset: i_rst_n is synchronous and active low. The key memory is then cleared one slot per
// cycle, every slot in turn, with s_axis_tready low; the capacity returns to 64.
//
// Stall: the result waits in an output register while the next request is taken; if that
// request finishes before the word is taken, the block holds its own result and accepts
// nothing further until then.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BYTES   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: capacity in use.
    input  logic                 i_cfg_wen,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    // Request channel.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata, from bit 0 up: mode[1:0], key[65:2], zero padding [71:66].
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Result channel.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata, from bit 0 up: status[2:0], slot[8:3], entry_count[15:9],
    // table_empty[16], table_full[17], zero padding [23:18].
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Address, count and arithmetic widths. EW is wide enough for any
    // index plus one, for the capacity and for the occupied count.
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int EW   = (AW + 1 > 8) ? AW + 1 : 8;
    localparam int KW   = 8 * KEY_BYTES;
    localparam int SW   = $clog2(255 * KEY_BYTES + 1);
    localparam int DCW  = $clog2(SW);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // Key memory: one write port and one registered read port.
    logic [KW-1:0] r_mem [TABLE_DEPTH];
    logic [KW-1:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [KW-1:0] mem_wd;
    logic          mem_re;

    logic [2:0]          r_state, n_state;
    logic [CAP_W-1:0]    r_cap;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [KW-1:0]       r_key, n_key;
    logic [SW-1:0]       r_num, n_num;
    logic [CAP_W-1:0]    r_rem, n_rem;
    logic [DCW-1:0]      r_dcnt, n_dcnt;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CAP_W-1:0]    r_issued, n_issued;
    logic [CAP_W-1:0]    r_exam, n_exam;
    logic                r_pend_vld, n_pend_vld;
    logic [AW-1:0]       r_pend_idx, n_pend_idx;
    logic [CNTW-1:0]     r_count, n_count;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [AW-1:0]       r_slot, n_slot;
    logic                r_out_vld, n_out_vld;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    logic [MODE_W-1:0] in_mode;
    logic [KW-1:0]     in_key;
    logic [SW-1:0]     in_sum;
    logic [EW-1:0]     cap_e;
    logic [EW-1:0]     idx_inc;
    logic [AW-1:0]     idx_wrap;
    logic [CAP_W:0]    div_try;
    logic [CAP_W-1:0]  div_rem;
    logic [EW-1:0]     div_rem_e;
    logic              last_exam;
    logic              out_load;
    logic [EW-1:0]     slot_e;
    logic [EW-1:0]     count_e;

    // Key bytes above KEY_BYTES are ignored.
    assign in_mode = s_axis_tdata[MODE_W-1:0];
    assign in_key  = s_axis_tdata[MODE_W +: KW];

    always_comb begin
        in_sum = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            in_sum = in_sum + SW'(in_key[8*i +: 8]);
        end
    end

    // Effective capacity: zero acts as one, and it never exceeds the depth.
    always_comb begin
        cap_e = EW'(r_cap);
        if (r_cap == '0) begin
            cap_e = EW'(1);
        end else if (EW'(r_cap) > EW'(TABLE_DEPTH)) begin
            cap_e = EW'(TABLE_DEPTH);
        end
    end

    // Next probe address, wrapping at the capacity in use.
    assign idx_inc  = EW'(r_idx) + EW'(1);
    assign idx_wrap = (idx_inc == cap_e) ? '0 : idx_inc[AW-1:0];

    // One step of the restoring divider for the home slot.
    always_comb begin
        div_try = {r_rem, r_num[SW-1]};
        if (div_try >= {1'b0, cap_e[CAP_W-1:0]}) begin
            div_try = div_try - {1'b0, cap_e[CAP_W-1:0]};
        end
        div_rem   = div_try[CAP_W-1:0];
        div_rem_e = EW'(div_rem);
    end

    assign last_exam = (EW'(r_exam) + EW'(1)) == cap_e;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assign out_load = (r_state == S_FIN) && (!r_out_vld || m_axis_tready);
    assign slot_e   = EW'(r_slot);
    assign count_e  = EW'(r_count);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_key      = r_key;
        n_num      = r_num;
        n_rem      = r_rem;
        n_dcnt     = r_dcnt;
        n_idx      = r_idx;
        n_issued   = r_issued;
        n_exam     = r_exam;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_count    = r_count;
        n_status   = r_status;
        n_slot     = r_slot;
        mem_we     = 1'b0;
        mem_wa     = r_idx;
        mem_wd     = '0;
        mem_re     = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + AW'(1);
                if (r_idx == AW'(TABLE_DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode = in_mode;
                    n_key  = in_key;
                    n_num  = in_sum;
                    n_rem  = '0;
                    n_dcnt = DCW'(SW - 1);
                    if (in_key == '0) begin
                        n_status = ST_ZERO_KEY;
                        n_slot   = '0;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = div_rem;
                n_num  = r_num << 1;
                n_dcnt = r_dcnt - DCW'(1);
                if (r_dcnt == '0) begin
                    n_idx      = div_rem_e[AW-1:0];
                    n_issued   = '0;
                    n_exam     = '0;
                    n_pend_vld = 1'b0;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                // Issue the read of the next slot while the previous one
                // is examined. Reads past the end of the probe are dropped.
                if (EW'(r_issued) < cap_e) begin
                    mem_re     = 1'b1;
                    n_pend_vld = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = idx_wrap;
                    n_issued   = r_issued + CAP_W'(1);
                end else begin
                    n_pend_vld = 1'b0;
                end

                if (r_pend_vld) begin
                    n_exam = r_exam + CAP_W'(1);
                    if (r_mode == MODE_INSERT) begin
                        if (r_rd_data == '0) begin
                            mem_we   = 1'b1;
                            mem_wa   = r_pend_idx;
                            mem_wd   = r_key;
                            n_count  = r_count + CNTW'(1);
                            n_status = ST_INSERTED;
                            n_slot   = r_pend_idx;
                            n_state  = S_FIN;
                        end else if (last_exam) begin
                            n_status = ST_NO_ROOM;
                            n_slot   = '0;
                            n_state  = S_FIN;
                        end
                    end else begin
                        if (r_rd_data == r_key) begin
                            n_slot  = r_pend_idx;
                            n_state = S_FIN;
                            if (r_mode == MODE_DELETE) begin
                                mem_we   = 1'b1;
                                mem_wa   = r_pend_idx;
                                mem_wd   = '0;
                                n_status = ST_DELETED;
                                if (r_count != '0) begin
                                    n_count = r_count - CNTW'(1);
                                end
                            end else begin
                                n_status = ST_FOUND;
                            end
                        end else if (r_rd_data == '0 || last_exam) begin
                            n_slot   = '0;
                            n_state  = S_FIN;
                            n_status = (r_mode == MODE_DELETE) ? ST_ABSENT
                                                               : ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result word and its valid flag.
    always_comb begin
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        if (out_load) begin
            n_out_vld  = 1'b1;
            n_out_data = '0;
            n_out_data[2:0]  = r_status;
            n_out_data[8:3]  = slot_e[SLOT_W-1:0];
            n_out_data[15:9] = count_e[COUNT_W-1:0];
            n_out_data[16]   = (r_count == '0);
            n_out_data[17]   = (count_e >= cap_e);
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cap      <= CAP_RESET;
            r_idx      <= '0;
            r_count    <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_wen) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_dcnt     <= n_dcnt;
        r_issued   <= n_issued;
        r_exam     <= n_exam;
        r_pend_idx <= n_pend_idx;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_out_data <= n_out_data;
    end

    // One request at a time: the cycle after a request is taken the input
    // side is closed.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // Probe addresses stay inside the capacity in use.
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> EW'(r_idx) < cap_e)
        else $error("probe address beyond capacity");

    // The occupied count never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_count) <= EW'(TABLE_DEPTH))
        else $error("occupied count out of range");

    // A finished request that cannot hand over its result holds it.
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && r_out_vld && !m_axis_tready |=> r_state == S_FIN)
        else $error("result dropped while output stalled");

endmodule

FILE: tb/sv/tb_linear_probe_hash_table.sv
// Self-checking testbench for linear_probe_hash_table: a queue-fed request
// driver, a result monitor and a shadow copy of the key table.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BYTES   = 8;

    // The package names only insert and delete; the other two mode codes are
    // the search and the spare code, which the block treats as a search.
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } t_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  entry_count;
        logic                table_empty;
        logic                table_full;
    } t_outcome;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wen     = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata, from bit 0 up: mode[1:0], key[65:2], zero padding [71:66].
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata, from bit 0 up: status[2:0], slot[8:3], entry_count[15:9],
    // table_empty[16], table_full[17], zero padding [23:18].
    logic [M_TDATA_W-1:0] m_axis_tdata;

    linear_probe_hash_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow state of the block: the key table, its occupied count and the
    // capacity register as last written.
    logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    int               shadow_count = 0;
    logic [CAP_W-1:0] shadow_cap   = CAP_RESET;

    t_request         pending_requests [$];
    t_outcome         expected_outcomes [$];
    logic [KEY_W-1:0] key_pool [$];
    int               failures    = 0;
    bit               quiet_phase = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A run of this length is far beyond what the slowest correct run needs.
    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Works one request against the shadow table and returns the word that
    // the block must send back for it. The shadow table is updated in place.
    function automatic t_outcome predict_outcome(t_request req);
        t_outcome         res;
        logic [KEY_W-1:0] key;
        int               cap;
        int               byte_sum;
        int               home;
        int               idx;
        int               step;
        bit               done;
        bit               hit;
        key = req.key;
        if (KEY_BYTES < 8) begin
            key = key & ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
        end
        // Capacity zero behaves as one, anything above the depth as the depth.
        cap = (shadow_cap == 0) ? 1 : int'(shadow_cap);
        if (cap > TABLE_DEPTH) begin
            cap = TABLE_DEPTH;
        end
        res.slot = '0;
        if (key == '0) begin
            res.status = ST_ZERO_KEY;
        end else begin
            byte_sum = 0;
            for (int b = 0; b < 8; b++) begin
                byte_sum = byte_sum + int'(key[8*b +: 8]);
            end
            home = byte_sum % cap;
            done = 1'b0;
            hit  = 1'b0;
            step = 0;
            if (req.mode == MODE_INSERT) begin
                res.status = ST_NO_ROOM;
                while (!done && step < cap) begin
                    idx = (home + step) % cap;
                    if (shadow_keys[idx] == '0) begin
                        shadow_keys[idx] = key;
                        shadow_count++;
                        res.status = ST_INSERTED;
                        res.slot   = idx[SLOT_W-1:0];
                        done       = 1'b1;
                    end
                    step++;
                end
            end else begin
                // The probe stops at the first empty slot, so a hole left by
                // a delete hides every key stored beyond it.
                while (!done && step < cap) begin
                    idx = (home + step) % cap;
                    if (shadow_keys[idx] == '0) begin
                        done = 1'b1;
                    end else if (shadow_keys[idx] == key) begin
                        hit      = 1'b1;
                        res.slot = idx[SLOT_W-1:0];
                        done     = 1'b1;
                    end
                    step++;
                end
                if (req.mode == MODE_DELETE) begin
                    if (hit) begin
                        shadow_keys[res.slot] = '0;
                        if (shadow_count > 0) begin
                            shadow_count--;
                        end
                        res.status = ST_DELETED;
                    end else begin
                        res.status = ST_ABSENT;
                    end
                end else begin
                    res.status = hit ? ST_FOUND : ST_NOT_FOUND;
                end
            end
        end
        res.entry_count = shadow_count[COUNT_W-1:0];
        res.table_empty = (shadow_count == 0);
        res.table_full  = (shadow_count >= cap);
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int draw_gap();
        int roll;
        if (quiet_phase) begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(3, 1);
        end
        if (roll < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // A new key of random length; a few are all zero or use every bit.
    function automatic logic [KEY_W-1:0] draw_fresh_key();
        logic [KEY_W-1:0] key;
        int               len;
        int               roll;
        roll = $urandom_range(99);
        key  = {$urandom, $urandom};
        if (roll < 3) begin
            return '0;
        end
        if (roll < 15) begin
            return key;
        end
        len = $urandom_range(8, 1);
        if (len < 8) begin
            key = key & ((64'd1 << (8 * len)) - 64'd1);
        end
        return key;
    endfunction

    // A key that was inserted earlier, or one with its bytes reversed, which
    // has the same byte sum and so lands in the same probe cluster.
    function automatic logic [KEY_W-1:0] draw_known_key();
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] swapped;
        if (key_pool.size() == 0) begin
            return draw_fresh_key();
        end
        key = key_pool[$urandom_range(key_pool.size() - 1)];
        if ($urandom_range(6) == 0) begin
            for (int b = 0; b < 8; b++) begin
                swapped[8*b +: 8] = key[8*(7-b) +: 8];
            end
            key = swapped;
        end
        return key;
    endfunction

    function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    task automatic send(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key);
        t_request req;
        req.mode = mode;
        req.key  = key;
        pending_requests.push_back(req);
    endtask

    // Returns once every queued request has been taken and answered. The
    // check runs at the falling edge, when the clocked blocks have settled.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || s_axis_tvalid
                   || expected_outcomes.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called while the block is idle, so the shadow copy can follow at once.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        shadow_cap = value;
    endtask

    // Request driver. An accepted word is predicted at the edge that takes
    // it, so the expectations stay in the order of the requests. The next
    // word follows at once unless a gap is drawn.
    always @(posedge i_clk) begin : request_driver
        t_request             req;
        logic                 next_valid;
        logic [S_TDATA_W-1:0] next_data;
        static t_request      held_req;
        static int            send_gap = 0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_outcomes.push_back(predict_outcome(held_req));
                send_gap = draw_gap();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                next_valid = 1'b0;
                next_data  = s_axis_tdata;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() != 0) begin
                    req        = pending_requests.pop_front();
                    held_req   = req;
                    next_valid = 1'b1;
                    next_data  = {{(S_TDATA_W - KEY_W - MODE_W){1'b0}}, req.key, req.mode};
                end
                s_axis_tvalid <= next_valid;
                s_axis_tdata  <= next_data;
            end
        end
    end

    // Result monitor. It compares each taken word with the oldest
    // expectation and throttles tready with random stalls, some of which
    // start while the block is still probing.
    always @(posedge i_clk) begin : result_monitor
        t_outcome  want;
        static int stall = 0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result word 0x%h with nothing expected", m_axis_tdata);
                    failures++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("status", 7'(want.status), 7'(m_axis_tdata[2:0]));
                    check_field("slot", 7'(want.slot), 7'(m_axis_tdata[8:3]));
                    check_field("entry_count", want.entry_count, m_axis_tdata[15:9]);
                    check_field("table_empty", 7'(want.table_empty), 7'(m_axis_tdata[16]));
                    check_field("table_full", 7'(want.table_full), 7'(m_axis_tdata[17]));
                end
            end
            if (m_axis_tready) begin
                if ((m_axis_tvalid) || ($urandom_range(19) == 0)) begin
                    stall = draw_gap();
                end
                m_axis_tready <= (stall == 0);
            end else begin
                if (stall > 0) begin
                    stall--;
                end
                m_axis_tready <= (stall == 0);
            end
        end
    end

    // Stimulus sequencer: a directed part, then random phases, each with its
    // own capacity. Every phase ends with the sender holding back until all
    // results are in, so the capacity is only changed while the block idles.
    initial begin : stimulus
        logic [CAP_W-1:0]  cap;
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        int                roll;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            shadow_keys[s] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset capacity of 64. Keys 0x03, 0x0102 and 0x0201 share byte sum
        // three and form one cluster; deleting its middle leaves a hole that
        // hides the last key. Sum 63 wraps from the top slot back to slot 0.
        send(MODE_INSERT, 64'd0);
        send(MODE_SEARCH, 64'd0);
        send(MODE_INSERT, 64'h03);
        send(MODE_INSERT, 64'h0102);
        send(MODE_INSERT, 64'h0201);
        send(MODE_SEARCH, 64'h0201);
        send(MODE_DELETE, 64'h0102);
        send(MODE_SEARCH, 64'h0201);
        send(MODE_DELETE, 64'h0102);
        send(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send(MODE_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        send(MODE_INSERT, 64'h8000_0000_0000_0000);
        send(MODE_INSERT, 64'h3F00_0000_0000_0000);
        send(MODE_INSERT, 64'h3F);
        send(MODE_INSERT, 64'h03);
        send(MODE_SEARCH, 64'h3F);
        wait_idle();

        // Capacity zero acts as one slot, which is already taken.
        write_capacity(7'd0);
        send(MODE_INSERT, 64'hAA);
        send(MODE_DELETE, 64'h8000_0000_0000_0000);
        send(MODE_INSERT, 64'hAA);
        wait_idle();

        // The largest register value is clamped to the table depth.
        write_capacity(7'd127);
        send(MODE_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF);
        send(MODE_DELETE, 64'h55);
        wait_idle();

        // Shrinking below the stored count: the flag reads full at once.
        write_capacity(7'd2);
        send(MODE_INSERT, 64'h11);
        send(MODE_SEARCH, 64'h3F);
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            roll = $urandom_range(99);
            if (roll < 30) begin
                cap = CAP_W'($urandom_range(8, 1));
            end else if (roll < 55) begin
                cap = CAP_W'($urandom_range(24, 9));
            end else if (roll < 75) begin
                cap = 7'd64;
            end else if (roll < 85) begin
                cap = CAP_W'($urandom_range(63, 25));
            end else if (roll < 95) begin
                cap = CAP_W'($urandom_range(127, 65));
            end else begin
                cap = 7'd0;
            end
            quiet_phase = ($urandom_range(3) == 0);
            write_capacity(cap);
            for (int n = 0; n < 50; n++) begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    mode = MODE_INSERT;
                    key  = ($urandom_range(3) == 0) ? draw_known_key() : draw_fresh_key();
                    if (key != '0) begin
                        key_pool.push_back(key);
                    end
                end else begin
                    if (roll < 65) begin
                        mode = MODE_DELETE;
                    end else if (roll < 95) begin
                        mode = MODE_SEARCH;
                    end else begin
                        mode = MODE_SPARE;
                    end
                    key = ($urandom_range(3) != 0) ? draw_known_key() : draw_fresh_key();
                end
                send(mode, key);
            end
            // Remove this phase's keys again so the next capacity starts
            // from a sparse table instead of one that stays full.
            while (key_pool.size() != 0) begin
                send(MODE_DELETE, key_pool.pop_front());
            end
            wait_idle();
        end

        quiet_phase = 1'b0;
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (expected_outcomes.size() != 0) begin
            $error("%0d expected result words never arrived", expected_outcomes.size());
            failures++;
        end
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
